### hw/rtl/bdg_pkg.sv
package bdg_pkg;

	localparam int COUNT_BITS = 12;
	localparam int NUM_CAS    = 6;
	localparam int CAS_W      = 3;
	localparam int ISSUE_W    = 12;
	localparam int AMT_W      = 26;
	localparam int NCNT_W     = 12;
	localparam int REST_W     = 20;
	localparam int TOT_W      = COUNT_BITS + 7;
	localparam int SUM_W      = ((COUNT_BITS > NCNT_W) ? COUNT_BITS : NCNT_W) + 1;
	localparam int VAL_W      = 6;
	localparam int TV_W       = COUNT_BITS + VAL_W;
	localparam int WIDE_W     = (TOT_W > REST_W) ? TOT_W : REST_W;
	localparam int MUL_A_W    = AMT_W - 2;
	localparam int MUL_B_W    = 25;
	localparam int MUL_W      = MUL_A_W + MUL_B_W;
	localparam int SHIFT_W    = 5;
	localparam int PC_W       = 4;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [6:0]            CASH_UNIT = 7'd100;

	localparam logic [4:0]         CHK_DIV   = 5'd25;
	localparam logic [SHIFT_W-1:0] CHK_SHIFT = 5'd29;
	localparam logic [MUL_B_W-1:0] CHK_RECIP = MUL_B_W'(((64'd1 << 29) + 64'd24) / 64'd25);

	localparam logic [MUL_B_W-1:0] RECIP_50 = MUL_B_W'(((64'd1 << 26) + 64'd49) / 64'd50);
	localparam logic [MUL_B_W-1:0] RECIP_20 = MUL_B_W'(((64'd1 << 25) + 64'd19) / 64'd20);
	localparam logic [MUL_B_W-1:0] RECIP_10 = MUL_B_W'(((64'd1 << 24) + 64'd9) / 64'd10);
	localparam logic [MUL_B_W-1:0] RECIP_5  = MUL_B_W'(((64'd1 << 23) + 64'd4) / 64'd5);
	localparam logic [MUL_B_W-1:0] RECIP_2  = MUL_B_W'(((64'd1 << 21) + 64'd1) / 64'd2);
	localparam logic [MUL_B_W-1:0] RECIP_1  = MUL_B_W'(64'd1 << 20);

	localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
	localparam logic [PC_W-1:0] PC_DECODE   = 4'd1;
	localparam logic [PC_W-1:0] PC_CHECK    = 4'd2;
	localparam logic [PC_W-1:0] PC_STG_MUL  = 4'd3;
	localparam logic [PC_W-1:0] PC_STG_TAKE = 4'd4;
	localparam logic [PC_W-1:0] PC_STG_SUB  = 4'd5;
	localparam logic [PC_W-1:0] PC_REST     = 4'd6;
	localparam logic [PC_W-1:0] PC_FINISH   = 4'd7;
	localparam logic [PC_W-1:0] PC_DEP_ADD  = 4'd8;
	localparam logic [PC_W-1:0] PC_DEP_TOT  = 4'd9;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_MUL,
		OP_CHECK,
		OP_STG_MUL,
		OP_STG_TAKE,
		OP_STG_SUB,
		OP_REST,
		OP_FINISH,
		OP_DEP_ADD,
		OP_DEP_TOT
	} op_t;

	typedef enum logic [2:0] {
		BR_NEXT,
		BR_GOTO,
		BR_IF_DEPOSIT,
		BR_IF_REJECT,
		BR_IF_MORE,
		BR_WAIT_IN,
		BR_WAIT_OUT
	} br_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_MULT  = 3'd1,
		ST_EXCEEDS   = 3'd2,
		ST_PARTIAL   = 3'd3,
		ST_SATURATED = 3'd4
	} status_t;

	typedef struct packed {
		op_t             op;
		br_t             br;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic accept;
		logic commit;
	} ctl_t;

	typedef struct packed {
		logic deposit;
		logic reject;
		logic more;
		logic out_free;
	} flags_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			PC_IDLE:     w = '{OP_LOAD, BR_WAIT_IN, PC_DECODE};
			PC_DECODE:   w = '{OP_DIV_MUL, BR_IF_DEPOSIT, PC_DEP_ADD};
			PC_CHECK:    w = '{OP_CHECK, BR_IF_REJECT, PC_FINISH};
			PC_STG_MUL:  w = '{OP_STG_MUL, BR_NEXT, PC_IDLE};
			PC_STG_TAKE: w = '{OP_STG_TAKE, BR_NEXT, PC_IDLE};
			PC_STG_SUB:  w = '{OP_STG_SUB, BR_IF_MORE, PC_STG_MUL};
			PC_REST:     w = '{OP_REST, BR_NEXT, PC_IDLE};
			PC_FINISH:   w = '{OP_FINISH, BR_WAIT_OUT, PC_IDLE};
			PC_DEP_ADD:  w = '{OP_DEP_ADD, BR_NEXT, PC_IDLE};
			PC_DEP_TOT:  w = '{OP_DEP_TOT, BR_GOTO, PC_FINISH};
			default:     w = '{OP_NOP, BR_GOTO, PC_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [VAL_W-1:0] note_hundreds(input logic [CAS_W-1:0] idx);
		logic [VAL_W-1:0] v;
		case (idx)
			3'd0:    v = 6'd1;
			3'd1:    v = 6'd2;
			3'd2:    v = 6'd5;
			3'd3:    v = 6'd10;
			3'd4:    v = 6'd20;
			3'd5:    v = 6'd50;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [MUL_B_W-1:0] stg_recip(input logic [CAS_W-1:0] idx);
		logic [MUL_B_W-1:0] r;
		case (idx)
			3'd0:    r = RECIP_1;
			3'd1:    r = RECIP_2;
			3'd2:    r = RECIP_5;
			3'd3:    r = RECIP_10;
			3'd4:    r = RECIP_20;
			3'd5:    r = RECIP_50;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [SHIFT_W-1:0] stg_shift(input logic [CAS_W-1:0] idx);
		logic [SHIFT_W-1:0] s;
		case (idx)
			3'd0:    s = 5'd20;
			3'd1:    s = 5'd21;
			3'd2:    s = 5'd23;
			3'd3:    s = 5'd24;
			3'd4:    s = 5'd25;
			3'd5:    s = 5'd26;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

### hw/rtl/banknote_dispense_greedy.sv
// A paid withdrawal runs through six cassette stages of three microcode steps each.
// The microcode sequencer and its shared reciprocal multiplier work on one transaction at
// a time: a new transaction is taken only after the last one has committed its result.
// A finished result waits in the output register while the next transaction is computed.
// Reset (arst_n low) empties all cassettes, clears the total and drops out_valid.
module banknote_dispense_greedy (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [bdg_pkg::CAS_W-1:0]     cassette_index,
	input  logic [bdg_pkg::NCNT_W-1:0]    note_count,
	input  logic [bdg_pkg::AMT_W-1:0]     amount,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdg_pkg::ISSUE_W-1:0]   issued_5000,
	output logic [bdg_pkg::ISSUE_W-1:0]   issued_2000,
	output logic [bdg_pkg::ISSUE_W-1:0]   issued_1000,
	output logic [bdg_pkg::ISSUE_W-1:0]   issued_500,
	output logic [bdg_pkg::ISSUE_W-1:0]   issued_200,
	output logic [bdg_pkg::ISSUE_W-1:0]   issued_100,
	output logic [2:0]                    status,
	output logic [bdg_pkg::AMT_W-1:0]     undelivered,
	output logic [bdg_pkg::AMT_W-1:0]     cash_total
);
	import bdg_pkg::*;

	ctl_t               ctl;
	flags_t             flags;
	logic               idle;
	logic [ISSUE_W-1:0] issued [NUM_CAS];

	bdg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.flags    (flags),
		.ctl      (ctl),
		.idle     (idle)
	);

	bdg_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.flags          (flags),
		.mode           (mode),
		.cassette_index (cassette_index),
		.note_count     (note_count),
		.amount         (amount),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.issued         (issued),
		.status         (status),
		.undelivered    (undelivered),
		.cash_total     (cash_total)
	);

	assign in_stall    = !idle;
	assign issued_100  = issued[0];
	assign issued_200  = issued[1];
	assign issued_500  = issued[2];
	assign issued_1000 = issued[3];
	assign issued_2000 = issued[4];
	assign issued_5000 = issued[5];

endmodule

### hw/rtl/bdg_seq.sv
module bdg_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  bdg_pkg::flags_t flags,
	output bdg_pkg::ctl_t   ctl,
	output logic            idle
);
	import bdg_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	logic [PC_W-1:0] pc_inc;
	uword_t          uw;

	assign uw     = ucode(pc_q);
	assign pc_inc = PC_W'(pc_q + 1'b1);
	assign idle   = (uw.br == BR_WAIT_IN);

	always_comb begin
		case (uw.br)
			BR_NEXT:       pc_next = pc_inc;
			BR_GOTO:       pc_next = uw.target;
			BR_IF_DEPOSIT: pc_next = flags.deposit ? uw.target : pc_inc;
			BR_IF_REJECT:  pc_next = flags.reject ? uw.target : pc_inc;
			BR_IF_MORE:    pc_next = flags.more ? uw.target : pc_inc;
			BR_WAIT_IN:    pc_next = in_valid ? uw.target : pc_q;
			BR_WAIT_OUT:   pc_next = flags.out_free ? uw.target : pc_q;
			default:       pc_next = PC_IDLE;
		endcase
	end

	always_comb begin
		ctl.op     = uw.op;
		ctl.accept = idle && in_valid;
		ctl.commit = (uw.op == OP_FINISH) && flags.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_DEP_TOT)
		else $error("Step counter left the program.");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> (pc_q == PC_DECODE))
		else $error("Accepted transaction did not start decoding.");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> (pc_q == PC_IDLE))
		else $error("Result commit did not return to idle.");

endmodule

### hw/rtl/bdg_dp.sv
module bdg_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bdg_pkg::ctl_t                ctl,
	output bdg_pkg::flags_t              flags,
	input  logic                         mode,
	input  logic [bdg_pkg::CAS_W-1:0]    cassette_index,
	input  logic [bdg_pkg::NCNT_W-1:0]   note_count,
	input  logic [bdg_pkg::AMT_W-1:0]    amount,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [bdg_pkg::ISSUE_W-1:0]  issued [bdg_pkg::NUM_CAS],
	output logic [2:0]                   status,
	output logic [bdg_pkg::AMT_W-1:0]    undelivered,
	output logic [bdg_pkg::AMT_W-1:0]    cash_total
);
	import bdg_pkg::*;

	logic [COUNT_BITS-1:0] cnt_q [NUM_CAS];
	logic [TOT_W-1:0]      tot_q;
	logic [CAS_W-1:0]      cas_q;
	logic                  out_valid_q;

	logic                  mode_q;
	logic [NCNT_W-1:0]     ncnt_q;
	logic [AMT_W-1:0]      amt_q;
	logic [REST_W-1:0]     rest_q;
	logic [MUL_W-1:0]      prod_q;
	logic [COUNT_BITS-1:0] take_q;
	logic [NCNT_W-1:0]     delta_q;
	logic [ISSUE_W-1:0]    iss_q [NUM_CAS];
	status_t               status_q;
	logic [AMT_W-1:0]      undeliv_q;

	logic [ISSUE_W-1:0]    out_iss_q [NUM_CAS];
	status_t               out_status_q;
	logic [AMT_W-1:0]      out_undeliv_q;
	logic [AMT_W-1:0]      out_cash_q;

	logic                  cas_ok;
	logic [COUNT_BITS-1:0] cur;
	logic [VAL_W-1:0]      val;
	logic [MUL_A_W-1:0]    mul_a;
	logic [MUL_B_W-1:0]    mul_b;
	logic [REST_W-1:0]     chk_q;
	logic [MUL_B_W-1:0]    chk_back;
	logic                  mult_ok;
	logic                  exceeds;
	logic [REST_W-1:0]     stg_q;
	logic [COUNT_BITS-1:0] take;
	logic [TV_W-1:0]       tv;
	logic [SUM_W-1:0]      sum;
	logic                  sat;
	logic [COUNT_BITS-1:0] dep_new;
	logic [NCNT_W+VAL_W-1:0] dv;
	logic [TOT_W+6:0]      cash_full;
	logic                  out_free;

	assign cas_ok   = (cas_q < CAS_W'(NUM_CAS));
	assign cur      = cas_ok ? cnt_q[cas_q] : '0;
	assign val      = note_hundreds(cas_q);

	assign mul_a    = (ctl.op == OP_DIV_MUL) ? amt_q[AMT_W-1:2] : MUL_A_W'(rest_q);
	assign mul_b    = (ctl.op == OP_DIV_MUL) ? CHK_RECIP : stg_recip(cas_q);

	assign chk_q    = REST_W'(prod_q >> CHK_SHIFT);
	assign chk_back = MUL_B_W'(chk_q) * MUL_B_W'(CHK_DIV);
	assign mult_ok  = (amt_q[1:0] == 2'b00) && (chk_back == MUL_B_W'(amt_q[AMT_W-1:2]));
	assign exceeds  = WIDE_W'(chk_q) > WIDE_W'(tot_q);

	assign stg_q    = REST_W'(prod_q >> stg_shift(cas_q));
	assign take     = (stg_q < REST_W'(cur)) ? COUNT_BITS'(stg_q) : cur;
	assign tv       = TV_W'(take_q) * TV_W'(val);

	assign sum      = SUM_W'(cur) + SUM_W'(ncnt_q);
	assign sat      = sum > SUM_W'(COUNT_MAX);
	assign dep_new  = sat ? COUNT_MAX : COUNT_BITS'(sum);
	assign dv       = (NCNT_W+VAL_W)'(delta_q) * (NCNT_W+VAL_W)'(val);

	assign cash_full = (TOT_W+7)'(tot_q) * (TOT_W+7)'(CASH_UNIT);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		flags.deposit  = !mode_q;
		flags.reject   = !mult_ok || exceeds;
		flags.more     = (cas_q != '0);
		flags.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CAS; i++) begin
				cnt_q[i] <= '0;
			end
			tot_q       <= '0;
			cas_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (ctl.op)
				OP_LOAD: begin
					if (ctl.accept) begin
						cas_q <= mode ? CAS_W'(NUM_CAS - 1) : cassette_index;
					end
				end
				OP_STG_TAKE: begin
					cnt_q[cas_q] <= cur - take;
				end
				OP_STG_SUB: begin
					tot_q <= tot_q - TOT_W'(tv);
					if (cas_q != '0) begin
						cas_q <= cas_q - 1'b1;
					end
				end
				OP_DEP_ADD: begin
					if (cas_ok) begin
						cnt_q[cas_q] <= dep_new;
					end
				end
				OP_DEP_TOT: begin
					tot_q <= tot_q + TOT_W'(dv);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				if (ctl.accept) begin
					mode_q    <= mode;
					ncnt_q    <= note_count;
					amt_q     <= amount;
					status_q  <= ST_OK;
					undeliv_q <= '0;
					delta_q   <= '0;
					for (int i = 0; i < NUM_CAS; i++) begin
						iss_q[i] <= '0;
					end
				end
			end
			OP_DIV_MUL, OP_STG_MUL: begin
				prod_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
			end
			OP_CHECK: begin
				rest_q <= chk_q;
				if (!mult_ok) begin
					status_q <= ST_NOT_MULT;
				end else if (exceeds) begin
					status_q <= ST_EXCEEDS;
				end
			end
			OP_STG_TAKE: begin
				take_q       <= take;
				iss_q[cas_q] <= ISSUE_W'(take);
			end
			OP_STG_SUB: begin
				rest_q <= rest_q - REST_W'(tv);
			end
			OP_REST: begin
				if (rest_q != '0) begin
					status_q  <= ST_PARTIAL;
					undeliv_q <= AMT_W'((REST_W+7)'(rest_q) * (REST_W+7)'(CASH_UNIT));
				end
			end
			OP_DEP_ADD: begin
				if (cas_ok) begin
					delta_q <= NCNT_W'(dep_new - cur);
					if (sat) begin
						status_q <= ST_SATURATED;
					end
				end
			end
			OP_FINISH: begin
				if (ctl.commit) begin
					out_iss_q     <= iss_q;
					out_status_q  <= status_q;
					out_undeliv_q <= undeliv_q;
					out_cash_q    <= AMT_W'(cash_full);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign issued      = out_iss_q;
	assign status      = out_status_q;
	assign undelivered = out_undeliv_q;
	assign cash_total  = out_cash_q;

	a_sub_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_STG_SUB) |-> (WIDE_W'(tv) <= WIDE_W'(rest_q)))
		else $error("Payout exceeds the remaining amount.");

	a_take_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_STG_TAKE) |-> (take <= cur))
		else $error("Payout exceeds the cassette count.");

	a_partial_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == ST_PARTIAL)) |-> (out_undeliv_q != '0))
		else $error("Partial payout reported with nothing undelivered.");

endmodule

### dv/banknote_dispense_greedy_tb.sv
module banknote_dispense_greedy_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bdg_pkg::*;

	localparam int RANDOM_ITEMS = 500;
	localparam int LONG_HOLD = 250;
	localparam int HOLD_AT_RESULT = 40;
	localparam int DRAIN_CYCLES = 40;
	localparam int NUM_ROWS = 26;
	localparam longint NOTE_VALUE [NUM_CAS] = '{100, 200, 500, 1000, 2000, 5000};

	typedef struct packed {
		logic [ISSUE_W-1:0] n5000;
		logic [ISSUE_W-1:0] n2000;
		logic [ISSUE_W-1:0] n1000;
		logic [ISSUE_W-1:0] n500;
		logic [ISSUE_W-1:0] n200;
		logic [ISSUE_W-1:0] n100;
		status_t            st;
		logic [AMT_W-1:0]   undelivered;
		logic [AMT_W-1:0]   cash;
	} payout_t;

	typedef struct {
		logic              md;
		logic [CAS_W-1:0]  idx;
		logic [NCNT_W-1:0] cnt;
		logic [AMT_W-1:0]  amt;
		bit                typed;
		status_t           st;
		logic [AMT_W-1:0]  cash;
	} row_t;

	// Rows marked typed carry the expected status and total; issued counts and the
	// undelivered part are zero for them. The others go through the predictor.
	row_t directed_rows [NUM_ROWS] = '{
		'{1'b1, 3'd0, 12'd0,    26'd0,        1'b1, ST_OK,        26'd0},
		'{1'b1, 3'd0, 12'd0,    26'd100,      1'b1, ST_EXCEEDS,   26'd0},
		'{1'b1, 3'd7, 12'd4095, 26'd67108863, 1'b1, ST_NOT_MULT,  26'd0},
		'{1'b1, 3'd0, 12'd0,    26'd67108800, 1'b1, ST_EXCEEDS,   26'd0},
		'{1'b0, 3'd7, 12'd4095, 26'd67108863, 1'b1, ST_OK,        26'd0},
		'{1'b0, 3'd6, 12'd4095, 26'd0,        1'b1, ST_OK,        26'd0},
		'{1'b0, 3'd0, 12'd0,    26'd0,        1'b1, ST_OK,        26'd0},
		'{1'b0, 3'd1, 12'd3,    26'd0,        1'b1, ST_OK,        26'd600},
		'{1'b1, 3'd0, 12'd0,    26'd100,      1'b0, ST_OK,        26'd0},
		'{1'b1, 3'd0, 12'd0,    26'd600,      1'b0, ST_OK,        26'd0},
		'{1'b0, 3'd5, 12'd4095, 26'd0,        1'b1, ST_OK,        26'd20475000},
		'{1'b0, 3'd5, 12'd1,    26'd0,        1'b1, ST_SATURATED, 26'd20475000},
		'{1'b0, 3'd4, 12'd4095, 26'd0,        1'b1, ST_OK,        26'd28665000},
		'{1'b0, 3'd3, 12'd4095, 26'd0,        1'b1, ST_OK,        26'd32760000},
		'{1'b0, 3'd2, 12'd4095, 26'd0,        1'b1, ST_OK,        26'd34807500},
		'{1'b0, 3'd1, 12'd4095, 26'd0,        1'b1, ST_OK,        26'd35626500},
		'{1'b0, 3'd0, 12'd4095, 26'd0,        1'b1, ST_OK,        26'd36036000},
		'{1'b0, 3'd0, 12'd4095, 26'd0,        1'b1, ST_SATURATED, 26'd36036000},
		'{1'b1, 3'd0, 12'd0,    26'd36036100, 1'b1, ST_EXCEEDS,   26'd36036000},
		'{1'b1, 3'd5, 12'd2048, 26'd36036050, 1'b1, ST_NOT_MULT,  26'd36036000},
		'{1'b1, 3'd0, 12'd0,    26'd36036000, 1'b0, ST_OK,        26'd0},
		'{1'b0, 3'd2, 12'd1,    26'd0,        1'b1, ST_OK,        26'd500},
		'{1'b1, 3'd0, 12'd0,    26'd300,      1'b0, ST_OK,        26'd0},
		'{1'b1, 3'd0, 12'd0,    26'd500,      1'b0, ST_OK,        26'd0},
		'{1'b0, 3'd3, 12'd2,    26'd0,        1'b1, ST_OK,        26'd2000},
		'{1'b1, 3'd0, 12'd0,    26'd1700,     1'b0, ST_OK,        26'd0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                mode = 1'b0;
	logic [CAS_W-1:0]    cassette_index = '0;
	logic [NCNT_W-1:0]   note_count = '0;
	logic [AMT_W-1:0]    amount = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [ISSUE_W-1:0]  issued_5000;
	logic [ISSUE_W-1:0]  issued_2000;
	logic [ISSUE_W-1:0]  issued_1000;
	logic [ISSUE_W-1:0]  issued_500;
	logic [ISSUE_W-1:0]  issued_200;
	logic [ISSUE_W-1:0]  issued_100;
	logic [2:0]          status;
	logic [AMT_W-1:0]    undelivered;
	logic [AMT_W-1:0]    cash_total;

	logic [COUNT_BITS-1:0] notes_held [NUM_CAS];
	payout_t               expected_payouts [$];
	int                    mismatches = 0;
	int                    payouts_seen = 0;
	int                    send_quiet = 0;
	int                    recv_quiet = 0;

	banknote_dispense_greedy dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.cassette_index(cassette_index),
		.note_count(note_count),
		.amount(amount),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.issued_5000(issued_5000),
		.issued_2000(issued_2000),
		.issued_1000(issued_1000),
		.issued_500(issued_500),
		.issued_200(issued_200),
		.issued_100(issued_100),
		.status(status),
		.undelivered(undelivered),
		.cash_total(cash_total)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint cash_held();
		longint t;
		int i;
		t = 0;
		for (i = 0; i < NUM_CAS; i++) begin
			t += longint'(notes_held[i]) * NOTE_VALUE[i];
		end
		return t;
	endfunction

	function automatic payout_t dispense_predict(input logic md, input logic [CAS_W-1:0] idx,
			input logic [NCNT_W-1:0] cnt, input logic [AMT_W-1:0] amt);
		payout_t p;
		longint sum;
		longint rest;
		longint want;
		longint take;
		longint taken [NUM_CAS];
		int i;
		p = '0;
		p.st = ST_OK;
		for (i = 0; i < NUM_CAS; i++) begin
			taken[i] = 0;
		end
		if (md == 1'b0) begin
			if (idx < NUM_CAS) begin
				sum = longint'(notes_held[idx]) + longint'(cnt);
				if (sum > longint'(COUNT_MAX)) begin
					sum = longint'(COUNT_MAX);
					p.st = ST_SATURATED;
				end
				notes_held[idx] = COUNT_BITS'(sum);
			end
		end else if (longint'(amt) % 100 != 0) begin
			p.st = ST_NOT_MULT;
		end else if (longint'(amt) > cash_held()) begin
			p.st = ST_EXCEEDS;
		end else begin
			rest = longint'(amt);
			for (i = NUM_CAS - 1; i >= 0; i--) begin
				want = rest / NOTE_VALUE[i];
				take = (want <= longint'(notes_held[i])) ? want : longint'(notes_held[i]);
				notes_held[i] = COUNT_BITS'(longint'(notes_held[i]) - take);
				rest -= take * NOTE_VALUE[i];
				taken[i] = take;
			end
			if (rest != 0) begin
				p.st = ST_PARTIAL;
				p.undelivered = AMT_W'(rest);
			end
		end
		p.n5000 = ISSUE_W'(taken[5]);
		p.n2000 = ISSUE_W'(taken[4]);
		p.n1000 = ISSUE_W'(taken[3]);
		p.n500 = ISSUE_W'(taken[2]);
		p.n200 = ISSUE_W'(taken[1]);
		p.n100 = ISSUE_W'(taken[0]);
		p.cash = AMT_W'(cash_held());
		return p;
	endfunction

	// Mostly a random wait per transaction, with occasional stretches of none.
	function automatic int draw_wait(ref int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: mismatch on %s, got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic offer_transaction(input logic md, input logic [CAS_W-1:0] idx,
			input logic [NCNT_W-1:0] cnt, input logic [AMT_W-1:0] amt,
			input bit typed, input status_t t_st, input logic [AMT_W-1:0] t_cash);
		int gap;
		payout_t p;
		gap = draw_wait(send_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		cassette_index <= idx;
		note_count <= cnt;
		amount <= amt;
		do @(posedge clk); while (in_stall);
		p = dispense_predict(md, idx, cnt, amt);
		if (typed) begin
			p = '0;
			p.st = t_st;
			p.cash = t_cash;
		end
		expected_payouts.push_back(p);
	endtask

	task automatic check_payout();
		payout_t want;
		if (expected_payouts.size() == 0) begin
			report_mismatch("result with nothing pending", status, 0);
			return;
		end
		want = expected_payouts.pop_front();
		if (issued_5000 !== want.n5000) report_mismatch("issued_5000", issued_5000, want.n5000);
		if (issued_2000 !== want.n2000) report_mismatch("issued_2000", issued_2000, want.n2000);
		if (issued_1000 !== want.n1000) report_mismatch("issued_1000", issued_1000, want.n1000);
		if (issued_500 !== want.n500) report_mismatch("issued_500", issued_500, want.n500);
		if (issued_200 !== want.n200) report_mismatch("issued_200", issued_200, want.n200);
		if (issued_100 !== want.n100) report_mismatch("issued_100", issued_100, want.n100);
		if (status !== want.st) report_mismatch("status", status, want.st);
		if (undelivered !== want.undelivered) begin
			report_mismatch("undelivered", undelivered, want.undelivered);
		end
		if (cash_total !== want.cash) report_mismatch("cash_total", cash_total, want.cash);
	endtask

	initial begin
		#5_000_000;
		$display("FAIL banknote_dispense_greedy");
		$finish;
	end

	// The receiver holds off once for a long stretch so that the block backs up
	// and stalls its input while the sender keeps offering.
	initial begin
		int hold;
		forever begin
			hold = (payouts_seen == HOLD_AT_RESULT) ? LONG_HOLD : draw_wait(recv_quiet);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			check_payout();
			payouts_seen++;
		end
	end

	initial begin
		int r;
		int counted;
		int pick;
		longint held;
		logic md;
		logic [CAS_W-1:0] idx;
		logic [NCNT_W-1:0] cnt;
		logic [AMT_W-1:0] amt;
		for (r = 0; r < NUM_CAS; r++) begin
			notes_held[r] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (r = 0; r < NUM_ROWS; r++) begin
			offer_transaction(directed_rows[r].md, directed_rows[r].idx, directed_rows[r].cnt,
				directed_rows[r].amt, directed_rows[r].typed, directed_rows[r].st,
				directed_rows[r].cash);
		end
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			held = cash_held();
			idx = CAS_W'($urandom());
			cnt = NCNT_W'($urandom());
			amt = AMT_W'($urandom());
			if (pick < 35) begin
				md = 1'b0;
				if ($urandom_range(0, 7) != 0) cnt = NCNT_W'($urandom_range(0, 40));
			end else begin
				md = 1'b1;
				if (pick < 60) begin
					amt = AMT_W'(100 * $urandom_range(0, int'(held / 100)));
				end else if (pick < 80) begin
					amt = AMT_W'(100 * $urandom_range(0, int'(((held < 20000) ? held : 20000) / 100)));
				end else if (pick >= 90) begin
					amt = AMT_W'(held + 100 * $urandom_range(1, 2000));
				end
			end
			offer_transaction(md, idx, cnt, amt, 1'b0, ST_OK, '0);
			if (md == 1'b1 || idx < NUM_CAS) counted++;
		end
		in_valid <= 1'b0;
		while (expected_payouts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_payouts.size() == 0) begin
			$display("PASS banknote_dispense_greedy");
		end else begin
			$display("FAIL banknote_dispense_greedy");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/bdg_pkg.sv
hw/rtl/bdg_seq.sv
hw/rtl/bdg_dp.sv
hw/rtl/banknote_dispense_greedy.sv
dv/banknote_dispense_greedy_tb.sv
